FILE: src/amrr_pkg.sv
// Shared types and constants for the alpha mask to region rectangle block.
// Used by the front end, the job queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package amrr_pkg;

    localparam int COORD_W     = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVEX_MODE  = 2'd2;

    // Result kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_EXTEND = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic   kind;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } rect_t;

    // All results caused by one pixel
    typedef struct packed {
        logic [1:0]      count;
        rect_t [1:0]     rect;
    } job_t;

    function automatic rect_t make_rect(input logic kind, input coord_t l, input coord_t t,
                                        input coord_t r, input coord_t b);
        rect_t x;
        x.kind   = kind;
        x.left   = l;
        x.top    = t;
        x.right  = r;
        x.bottom = b;
        return x;
    endfunction

endpackage

`default_nettype wire

FILE: src/alpha_mask_to_region_rects.sv
// Top level of the alpha mask to region rectangle block.
// Instantiates amrr_front, amrr_queue and amrr_back; uses amrr_pkg.
//
// Pixels (alpha bytes, row order, left to right) are accepted one per clock
// while in_ready is high. The front end updates the row and run tracking in
// the cycle a pixel is accepted and files a job of up to two rectangles into
// a four-entry queue; pixels that cause no rectangle take no queue slot. The
// back end delivers one rectangle per clock from a registered output while
// out_ready is high, so a pixel that causes two rectangles gives two output
// transfers, and input ready drops only while the queue is full. There is no
// clearing pass after reset. Configuration writes take effect on the next
// clock and belong between images, with the block idle.
`timescale 1ns / 1ps
`default_nettype none

module alpha_mask_to_region_rects #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [amrr_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  wire  [amrr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [7:0]                        alpha,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              kind,
    output logic [amrr_pkg::COORD_W-1:0]      rect_left,
    output logic [amrr_pkg::COORD_W-1:0]      rect_top,
    output logic [amrr_pkg::COORD_W-1:0]      rect_right,
    output logic [amrr_pkg::COORD_W-1:0]      rect_bottom,
    output logic                              last_of_run
);
    import amrr_pkg::*;

    logic  accept, push, pop, empty, full;
    job_t  push_job, head_job;
    rect_t out_rect;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    amrr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .alpha     (alpha),
        .push      (push),
        .push_job  (push_job)
    );

    amrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    amrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rect  (out_rect),
        .out_last  (last_of_run)
    );

    assign kind        = out_rect.kind;
    assign rect_left   = out_rect.left;
    assign rect_top    = out_rect.top;
    assign rect_right  = out_rect.right;
    assign rect_bottom = out_rect.bottom;

endmodule

`default_nettype wire

FILE: src/amrr_front.sv
// Front end: configuration registers, pixel counters and run tracking.
// Classifies each accepted pixel into a job of zero to two rectangles; uses amrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amrr_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [amrr_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  wire  [amrr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                               accept,
    input  wire  [7:0]                        alpha,
    output logic                              push,
    output amrr_pkg::job_t                    push_job
);
    import amrr_pkg::*;

    localparam int DIM_W = 17;
    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

    coord_t     image_width_reg, image_height_reg;
    logic       convex_mode_reg;

    coord_t     column_count_reg, column_count_next;
    coord_t     row_count_reg, row_count_next;
    coord_t     row_first_opaque_reg, row_first_opaque_next;
    coord_t     row_last_opaque_end_reg, row_last_opaque_end_next;
    logic       run_open_reg, run_open_next;
    coord_t     open_run_start_reg, open_run_start_next;
    coord_t     held_run_left_reg, held_run_left_next;
    coord_t     held_run_right_reg, held_run_right_next;
    logic [1:0] runs_in_row_reg, runs_in_row_next;
    logic       prev_span_valid_reg, prev_span_valid_next;
    coord_t     prev_span_left_reg, prev_span_left_next;
    coord_t     prev_span_right_reg, prev_span_right_next;
    coord_t     last_rect_top_reg, last_rect_top_next;

    logic [DIM_W-1:0] width_eff, height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= COORD_W'(MAX_WIDTH);
            image_height_reg <= COORD_W'(MAX_HEIGHT);
            convex_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                REG_CONVEX_MODE:  convex_mode_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX
    always_comb
    begin
        width_eff = DIM_W'(image_width_reg);
        if (width_eff == '0)
            width_eff = DIM_W'(1);
        else if (width_eff > MAX_W)
            width_eff = MAX_W;
        height_eff = DIM_W'(image_height_reg);
        if (height_eff == '0)
            height_eff = DIM_W'(1);
        else if (height_eff > MAX_H)
            height_eff = MAX_H;
    end

    always_comb
    begin
        coord_t           c, y, y1, c1, end_col, l, r;
        logic             convex, opaque;
        logic [DIM_W-1:0] c_wide, y_wide;
        logic [1:0]       cnt;
        rect_t [1:0]      rs;

        c      = column_count_reg;
        y      = row_count_reg;
        y1     = y + COORD_W'(1);
        c1     = c + COORD_W'(1);
        c_wide = DIM_W'(c) + DIM_W'(1);
        y_wide = DIM_W'(y) + DIM_W'(1);
        convex = convex_mode_reg;
        opaque = (alpha != 8'd0);
        cnt    = 2'd0;
        rs     = '0;
        l      = '0;
        r      = '0;

        column_count_next        = column_count_reg;
        row_count_next           = row_count_reg;
        row_first_opaque_next    = row_first_opaque_reg;
        row_last_opaque_end_next = row_last_opaque_end_reg;
        run_open_next            = run_open_reg;
        open_run_start_next      = open_run_start_reg;
        held_run_left_next       = held_run_left_reg;
        held_run_right_next      = held_run_right_reg;
        runs_in_row_next         = runs_in_row_reg;
        prev_span_valid_next     = prev_span_valid_reg;
        prev_span_left_next      = prev_span_left_reg;
        prev_span_right_next     = prev_span_right_reg;
        last_rect_top_next       = last_rect_top_reg;

        // Opaque pixel: open a run if none is open and note the row's opaque end
        if (opaque)
        begin
            if (!run_open_next)
            begin
                run_open_next       = 1'b1;
                open_run_start_next = c;
                if (runs_in_row_next == 2'd0)
                begin
                    row_first_opaque_next = c;
                    runs_in_row_next      = 2'd1;
                end
                else if (runs_in_row_next == 2'd1)
                begin
                    // second run proves the held first run is one of several
                    if (!convex)
                    begin
                        rs[cnt[0]] = make_rect(KIND_ADD, held_run_left_next, y,
                                               held_run_right_next, y1);
                        cnt = cnt + 2'd1;
                    end
                    runs_in_row_next = 2'd2;
                end
            end
            row_last_opaque_end_next = c1;
        end

        // Close an open run at a transparent pixel or at the row end
        end_col = opaque ? c1 : c;
        if (run_open_next && (!opaque || c_wide >= width_eff))
        begin
            run_open_next = 1'b0;
            if (runs_in_row_next == 2'd1)
            begin
                held_run_left_next  = open_run_start_next;
                held_run_right_next = end_col;
            end
            else if (!convex)
            begin
                rs[cnt[0]] = make_rect(KIND_ADD, open_run_start_next, y, end_col, y1);
                cnt = cnt + 2'd1;
            end
        end

        if (c_wide >= width_eff)
        begin
            if (runs_in_row_next == 2'd0 || (runs_in_row_next >= 2'd2 && !convex))
            begin
                prev_span_valid_next = 1'b0;
            end
            else
            begin
                l = convex ? row_first_opaque_next : held_run_left_next;
                r = convex ? row_last_opaque_end_next : held_run_right_next;
                if (prev_span_valid_next && l == prev_span_left_next
                    && r == prev_span_right_next)
                begin
                    rs[cnt[0]] = make_rect(KIND_EXTEND, l, last_rect_top_next, r, y1);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    rs[cnt[0]] = make_rect(KIND_ADD, l, y, r, y1);
                    cnt = cnt + 2'd1;
                    last_rect_top_next   = y;
                    prev_span_left_next  = l;
                    prev_span_right_next = r;
                    prev_span_valid_next = 1'b1;
                end
            end
            runs_in_row_next  = 2'd0;
            column_count_next = '0;
            row_count_next    = y1;
            // wrap at the last row and forget the span across images
            if (y_wide >= height_eff)
            begin
                row_count_next       = '0;
                prev_span_valid_next = 1'b0;
            end
        end
        else
        begin
            column_count_next = c1;
        end

        push           = accept && (cnt != 2'd0);
        push_job.count = cnt;
        push_job.rect  = rs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg        <= '0;
            row_count_reg           <= '0;
            row_first_opaque_reg    <= '0;
            row_last_opaque_end_reg <= '0;
            run_open_reg            <= 1'b0;
            open_run_start_reg      <= '0;
            held_run_left_reg       <= '0;
            held_run_right_reg      <= '0;
            runs_in_row_reg         <= 2'd0;
            prev_span_valid_reg     <= 1'b0;
            prev_span_left_reg      <= '0;
            prev_span_right_reg     <= '0;
            last_rect_top_reg       <= '0;
        end
        else if (accept)
        begin
            column_count_reg        <= column_count_next;
            row_count_reg           <= row_count_next;
            row_first_opaque_reg    <= row_first_opaque_next;
            row_last_opaque_end_reg <= row_last_opaque_end_next;
            run_open_reg            <= run_open_next;
            open_run_start_reg      <= open_run_start_next;
            held_run_left_reg       <= held_run_left_next;
            held_run_right_reg      <= held_run_right_next;
            runs_in_row_reg         <= runs_in_row_next;
            prev_span_valid_reg     <= prev_span_valid_next;
            prev_span_left_reg      <= prev_span_left_next;
            prev_span_right_reg     <= prev_span_right_next;
            last_rect_top_reg       <= last_rect_top_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/amrr_queue.sv
// Short job queue between the front end and the back end.
// Register-based FIFO of amrr_pkg::job_t entries, depth QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module amrr_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire amrr_pkg::job_t push_job,
    input  wire                pop,
    output amrr_pkg::job_t     head_job,
    output logic               empty,
    output logic               full
);
    import amrr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: src/amrr_back.sv
// Back end: unpacks queued jobs into single rectangle transactions.
// Holds the output register and a second-result stage; uses amrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amrr_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire amrr_pkg::job_t head_job,
    input  wire                empty,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_ready,
    output amrr_pkg::rect_t    out_rect,
    output logic               out_last
);
    import amrr_pkg::*;

    logic  out_valid_reg, out_valid_next;
    rect_t out_rect_reg, out_rect_next;
    logic  out_last_reg, out_last_next;
    logic  pend_valid_reg, pend_valid_next;
    rect_t pend_rect_reg, pend_rect_next;
    logic  load;

    // Refill the output slot when it is empty or being taken
    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rect_next   = out_rect_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_rect_next  = pend_rect_reg;
        pop             = 1'b0;
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rect_next   = pend_rect_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                pop             = 1'b1;
                out_valid_next  = 1'b1;
                out_rect_next   = head_job.rect[0];
                out_last_next   = (head_job.count == 2'd1);
                pend_valid_next = (head_job.count == 2'd2);
                pend_rect_next  = head_job.rect[1];
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rect_reg  <= out_rect_next;
        out_last_reg  <= out_last_next;
        pend_rect_reg <= pend_rect_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rect  = out_rect_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
